// ===== design/fan_heading_generator_top_defines.svh =====
// Assertion helpers used by the RTL.
`ifndef FAN_HEADING_GENERATOR_TOP_DEFINES_SVH
`define FAN_HEADING_GENERATOR_TOP_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define FHG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define FHG_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== design/fhg_pkg.sv =====
package fhg_pkg;

  localparam int TURN_COARSE = 92160;
  localparam int TURN_FINE = 23592960;
  localparam int QUARTER_FINE = 5898240;
  localparam int HALF_FINE = 11796480;
  localparam int GAIN_Q30 = 652032874;

  localparam int MAX_HEADINGS_DEF = 32;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int DW = 34;  // divider operand width
  localparam int NW = 34;  // offset numerator width
  localparam int AW = 28;  // fine angle width, signed
  localparam int XW = 34;  // CORDIC x/y width, signed
  localparam int QDEPTH = 4;

  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_SPIN = 2'd1;
  localparam logic [1:0] REG_ARC = 2'd2;
  localparam logic [1:0] REG_AIM = 2'd3;

  typedef struct packed {
    logic [15:0] volley_number;
    logic signed [15:0] target_dx;
    logic signed [15:0] target_dy;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] heading_x;
    logic signed [15:0] heading_y;
    logic last_heading;
  } out_word_t;

  typedef struct packed {
    logic [5:0] count;
    logic signed [17:0] spin;
    logic signed [17:0] arc;
    logic aim;
  } cfg_t;

  typedef struct packed {
    logic signed [AW-1:0] angle;
    logic last;
  } qent_t;

  typedef enum logic [3:0] {
    FS_IDLE, FS_MUL, FS_MOD, FS_MODW, FS_ATAN, FS_NUM, FS_DIV, FS_DIVW, FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE, BS_RED, BS_ROT, BS_OUT
  } back_state_t;

  // arctan(2^-i) in 1/65536 degree
  function automatic logic [21:0] atan_fine(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0: v = 22'd2949120;
      5'd1: v = 22'd1740967;
      5'd2: v = 22'd919879;
      5'd3: v = 22'd466945;
      5'd4: v = 22'd234379;
      5'd5: v = 22'd117304;
      5'd6: v = 22'd58666;
      5'd7: v = 22'd29335;
      5'd8: v = 22'd14668;
      5'd9: v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/fhg_div.sv =====
module fhg_div import fhg_pkg::*; #(
  parameter int W = DW
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dvd,
  input  logic [W-1:0] dvs,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CNW = $clog2(W);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [W:0]     rem_r, rem_nxt;
  logic [W-1:0]   quot_r, quot_nxt;
  logic [W-1:0]   dvs_r, dvs_nxt;
  logic [W:0]     trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    dvs_r  <= dvs_nxt;
  end

  // restoring division, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r[W-1:0], quot_r[W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quot_nxt = dvd;
      dvs_nxt  = dvs;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = trial - {1'b0, dvs_r};
        quot_nxt = {quot_r[W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r[W-1:0];

endmodule

// ===== design/fhg_front.sv =====
module fhg_front import fhg_pkg::*; #(
  parameter int MAX_HEADINGS = MAX_HEADINGS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_word_t in_data,
  input  cfg_t     cfg,
  output logic     busy,
  input  logic     q_full,
  output logic     q_push,
  output qent_t    q_data
);

  localparam int CW = $clog2(MAX_HEADINGS + 1);
  localparam int SW = $clog2(CORDIC_STEPS);
  localparam int MW = CW + 2;
  // full turn is 45 * 2^11: low 11 bits pass, the rest is reduced mod 45
  localparam logic [22:0] RECIP45 = 23'd5965233;  // ceil(2^28 / 45)

  front_state_t state_r, state_nxt;
  logic [15:0]  vol_r, vol_nxt;
  logic signed [15:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [17:0] spin_r, spin_nxt, arc_r, arc_nxt;
  logic [CW-1:0] c_r, c_nxt, d_r, d_nxt, k_r, k_nxt;
  logic signed [35:0] prod_r, prod_nxt;
  logic [16:0] mq_r, mq_nxt;
  logic signed [AW-1:0] base_r, base_nxt, cz_r, cz_nxt, off_r, off_nxt;
  logic signed [XW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [SW-1:0] it_r, it_nxt;
  logic signed [NW-1:0] num_r, num_nxt;

  logic          div_start, div_done;
  logic [DW-1:0] div_dvd, div_dvs, div_q, div_rem;

  logic [CW-1:0] cn;
  logic signed [17:0] spin_s, arc_s;
  logic signed [XW-1:0] xs, ys, x0;
  logic signed [AW-1:0] at;
  logic [32:0] aprod;
  logic [21:0] ahi, m45;
  logic [44:0] mprod;
  logic [5:0]  r45;
  logic [16:0] mrm, mr;
  logic signed [MW-1:0] mk;
  logic signed [25:0] arcf;
  logic signed [DW:0] qs;

  fhg_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dvd(div_dvd), .dvs(div_dvs),
    .done(div_done), .quot(div_q), .rem(div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    vol_r  <= vol_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    spin_r <= spin_nxt;
    arc_r  <= arc_nxt;
    c_r    <= c_nxt;
    d_r    <= d_nxt;
    k_r    <= k_nxt;
    prod_r <= prod_nxt;
    mq_r   <= mq_nxt;
    base_r <= base_nxt;
    cx_r   <= cx_nxt;
    cy_r   <= cy_nxt;
    cz_r   <= cz_nxt;
    it_r   <= it_nxt;
    num_r  <= num_nxt;
    off_r  <= off_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    vol_nxt = vol_r;  dx_nxt = dx_r;  dy_nxt = dy_r;
    spin_nxt = spin_r; arc_nxt = arc_r;
    c_nxt = c_r;  d_nxt = d_r;  k_nxt = k_r;
    prod_nxt = prod_r; mq_nxt = mq_r; base_nxt = base_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; it_nxt = it_r;
    num_nxt = num_r; off_nxt = off_r;
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = '0;
    q_push = 1'b0;
    q_data.angle = base_r + off_r;
    q_data.last = (k_r == c_r - 1'b1);

    cn = (8'(cfg.count) > 8'(MAX_HEADINGS)) ? CW'(MAX_HEADINGS) : CW'(cfg.count);
    spin_s = (cfg.spin > 18'sd92160) ? 18'sd92160 :
             (cfg.spin < -18'sd92160) ? -18'sd92160 : cfg.spin;
    arc_s = (cfg.arc > 18'sd92160) ? 18'sd92160 :
            (cfg.arc < -18'sd92160) ? -18'sd92160 : cfg.arc;

    xs = cx_r >>> it_r;
    ys = cy_r >>> it_r;
    at = $signed(AW'(atan_fine(5'(it_r))));
    // |spin * volley| stays below 2^33
    aprod = prod_r[35] ? 33'(-prod_r) : 33'(prod_r);
    ahi = aprod[32:11];
    mprod = {23'b0, ahi} * {22'b0, RECIP45};
    m45 = {5'b0, mq_r} * 22'd45;
    r45 = 6'(ahi - m45);
    mrm = {r45, aprod[10:0]};
    mr = (prod_r[35] && mrm != 17'd0) ? 17'(TURN_COARSE) - mrm : mrm;
    x0 = $signed(XW'(dx_r)) <<< 14;
    mk = $signed({1'b0, k_r, 1'b0}) - $signed({2'b0, c_r}) + MW'(1);
    arcf = {arc_r, 8'b0};
    qs = $signed({1'b0, div_q});
    if (num_r[NW-1]) begin
      qs = (div_rem != '0) ? -qs - 1'b1 : -qs;
    end

    unique case (state_r)
      FS_IDLE: begin
        if (start) begin
          vol_nxt = in_data.volley_number;
          dx_nxt = in_data.target_dx;
          dy_nxt = in_data.target_dy;
          spin_nxt = spin_s;
          arc_nxt = arc_s;
          c_nxt = cn;
          k_nxt = '0;
          if (cn < CW'(2)) begin
            d_nxt = '0;
          end else if (arc_s == 18'sd92160 || arc_s == -18'sd92160) begin
            d_nxt = cn;
          end else begin
            d_nxt = cn - 1'b1;
          end
          // nothing to emit: drop the word
          if (cn != '0 && !(cfg.aim && in_data.target_dx == '0 &&
                            in_data.target_dy == '0)) begin
            state_nxt = FS_MUL;
          end
        end
      end
      FS_MUL: begin
        prod_nxt = 36'(spin_r) * 36'($signed({1'b0, vol_r}));
        state_nxt = FS_MOD;
      end
      FS_MOD: begin
        // quotient of the upper bits by 45
        mq_nxt = mprod[44:28];
        state_nxt = FS_MODW;
      end
      FS_MODW: begin
        base_nxt = $signed(AW'({mr, 8'b0}));
        it_nxt = '0;
        cx_nxt = dx_r[15] ? -x0 : x0;
        cy_nxt = dx_r[15] ? -($signed(XW'(dy_r)) <<< 14) : ($signed(XW'(dy_r)) <<< 14);
        cz_nxt = dx_r[15] ? AW'(HALF_FINE) : '0;
        state_nxt = cfg.aim ? FS_ATAN : FS_NUM;
      end
      FS_ATAN: begin
        // vectoring: drive y to zero, z collects the angle
        if (cy_r > 0) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + at;
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - at;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == SW'(CORDIC_STEPS - 1)) begin
          base_nxt = base_r + cz_nxt;
          state_nxt = FS_NUM;
        end
      end
      FS_NUM: begin
        if (d_r == '0) begin
          off_nxt = '0;
          state_nxt = FS_PUSH;
        end else begin
          num_nxt = NW'(arcf) * NW'(mk) + NW'($signed({1'b0, d_r}));
          state_nxt = FS_DIV;
        end
      end
      FS_DIV: begin
        div_start = 1'b1;
        div_dvd = num_r[NW-1] ? DW'(-num_r) : DW'(num_r);
        div_dvs = DW'({d_r, 1'b0});
        state_nxt = FS_DIVW;
      end
      FS_DIVW: begin
        if (div_done) begin
          off_nxt = AW'(qs);
          state_nxt = FS_PUSH;
        end
      end
      FS_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          k_nxt = k_r + 1'b1;
          state_nxt = q_data.last ? FS_IDLE : FS_NUM;
        end
      end
      default: state_nxt = FS_IDLE;
    endcase
  end

  assign busy = (state_r != FS_IDLE);

endmodule

// ===== design/fhg_queue.sv =====
`include "fan_heading_generator_top_defines.svh"

module fhg_queue import fhg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  input  logic  pop,
  output qent_t pop_data,
  output logic  full,
  output logic  empty
);

  localparam int PW = $clog2(QDEPTH);

  qent_t         mem_r [QDEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push) - (PW+1)'(pop);
  end

  assign pop_data = mem_r[rp_r];
  assign full  = (cnt_r == (PW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);

  `FHG_ASSERT(a_cnt_bound, cnt_r <= (PW+1)'(QDEPTH), "queue count past depth")
  `FHG_ASSERT_IMP(a_no_overflow, full, !push, "push into full queue")
  `FHG_ASSERT_IMP(a_no_underflow, empty, !pop, "pop from empty queue")

endmodule

// ===== design/fhg_back.sv =====
module fhg_back import fhg_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  qent_t     q_data,
  output logic      q_pop,
  output logic      out_valid,
  output out_word_t out_data
);

  localparam int SW = $clog2(CORDIC_STEPS);

  back_state_t state_r, state_nxt;
  logic signed [AW-1:0] a_r, a_nxt, z_r, z_nxt;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [SW-1:0] it_r, it_nxt;
  logic neg_r, neg_nxt, last_r, last_nxt;
  logic vld_r, vld_nxt;
  out_word_t od_r, od_nxt;

  logic signed [XW-1:0] xs, ys, rx, ry;
  logic signed [AW-1:0] at;
  logic signed [15:0] cq, sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
    a_r    <= a_nxt;
    z_r    <= z_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    it_r   <= it_nxt;
    neg_r  <= neg_nxt;
    last_r <= last_nxt;
    od_r   <= od_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    a_nxt = a_r; z_nxt = z_r; x_nxt = x_r; y_nxt = y_r; it_nxt = it_r;
    neg_nxt = neg_r; last_nxt = last_r;
    vld_nxt = 1'b0;
    od_nxt = od_r;
    q_pop = 1'b0;
    xs = x_r >>> it_r;
    ys = y_r >>> it_r;
    at = $signed(AW'(atan_fine(5'(it_r))));
    // round half up to Q2.14, clamp to +-1.0
    rx = (x_r + XW'(32768)) >>> 16;
    ry = (y_r + XW'(32768)) >>> 16;
    cq = (rx > XW'(16384)) ? 16'sd16384 : (rx < -XW'(16384)) ? -16'sd16384 : 16'(rx);
    sq = (ry > XW'(16384)) ? 16'sd16384 : (ry < -XW'(16384)) ? -16'sd16384 : 16'(ry);

    unique case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          a_nxt = q_data.angle;
          last_nxt = q_data.last;
          state_nxt = BS_RED;
        end
      end
      BS_RED: begin
        // one turn per cycle into [0, turn), then fold to +-90 degrees
        if (a_r < 0) begin
          a_nxt = a_r + AW'(TURN_FINE);
        end else if (a_r >= AW'(TURN_FINE)) begin
          a_nxt = a_r - AW'(TURN_FINE);
        end else begin
          if (a_r > AW'(QUARTER_FINE) && a_r < AW'(3 * QUARTER_FINE)) begin
            z_nxt = a_r - AW'(HALF_FINE);
            neg_nxt = 1'b1;
          end else if (a_r >= AW'(3 * QUARTER_FINE)) begin
            z_nxt = a_r - AW'(TURN_FINE);
            neg_nxt = 1'b0;
          end else begin
            z_nxt = a_r;
            neg_nxt = 1'b0;
          end
          x_nxt = XW'(GAIN_Q30);
          y_nxt = '0;
          it_nxt = '0;
          state_nxt = BS_ROT;
        end
      end
      BS_ROT: begin
        if (z_r >= 0) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end
        it_nxt = it_r + 1'b1;
        if (it_r == SW'(CORDIC_STEPS - 1)) begin
          state_nxt = BS_OUT;
        end
      end
      BS_OUT: begin
        vld_nxt = 1'b1;
        od_nxt.heading_x = neg_r ? -cq : cq;
        od_nxt.heading_y = neg_r ? -sq : sq;
        od_nxt.last_heading = last_r;
        state_nxt = BS_IDLE;
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  assign out_valid = vld_r;
  assign out_data  = od_r;

endmodule

// ===== design/fan_heading_generator_top.sv =====
// Channel   Ports                               Handshake
// input     start, busy, in_data                taken when start && !busy
// result    out_valid, out_data                 one-cycle strobe, no backpressure
// config    psel, penable, pwrite, paddr,       APB write on access phase,
//           pwdata, prdata, pready              pready tied high
//
// Front: the base angle takes a multiply, then a reduction by a full turn
// with a reciprocal multiply, plus a CORDIC vectoring pass if aimed; then
// each heading's offset is divided out on the serial divider (no division
// for a single heading). Back: a CORDIC rotation per heading on the
// rotation unit; a 4-deep queue lets the two overlap.
// busy stays high until the front has queued the last heading of a word.
// Reset is synchronous, active low; config registers come up at their
// reset values. Results cannot be stalled.
module fan_heading_generator_top import fhg_pkg::*; #(
  parameter int MAX_HEADINGS = MAX_HEADINGS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_data,
  output logic        out_valid,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_pop, q_full, q_empty;
  qent_t q_in, q_out;
  logic  fr_start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count <= 6'd1;
      cfg_r.spin  <= '0;
      cfg_r.arc   <= '0;
      cfg_r.aim   <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_COUNT: cfg_nxt.count = pwdata[5:0];
        REG_SPIN:  cfg_nxt.spin  = $signed(pwdata[17:0]);
        REG_ARC:   cfg_nxt.arc   = $signed(pwdata[17:0]);
        REG_AIM:   cfg_nxt.aim   = pwdata[0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
    unique case (paddr[3:2])
      REG_COUNT: prdata = {26'b0, cfg_r.count};
      REG_SPIN:  prdata = 32'(cfg_r.spin);
      REG_ARC:   prdata = 32'(cfg_r.arc);
      REG_AIM:   prdata = {31'b0, cfg_r.aim};
      default:   prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign fr_start = start && !busy;

  fhg_front #(.MAX_HEADINGS(MAX_HEADINGS), .CORDIC_STEPS(CORDIC_STEPS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(fr_start), .in_data(in_data), .cfg(cfg_r),
    .busy(busy), .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  fhg_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .pop(q_pop),
    .pop_data(q_out), .full(q_full), .empty(q_empty)
  );

  fhg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_data(out_data)
  );

endmodule
